// File: rtl/qfr_pkg.sv
package qfr_pkg;

  localparam int CompW        = 16;
  localparam int PoseFracBits = 14;

  // p*b product and the four-term sum of the first Hamilton product
  localparam int ProdW = 2 * CompW;
  localparam int HelpW = ProdW + 2;
  // helper*p product and the four-term sum of the second Hamilton product
  localparam int Prod2W = HelpW + CompW;
  localparam int SumW   = Prod2W + 2;
  // scale of the exact sum is 2^(2F)
  localparam int RndShift = 2 * PoseFracBits;
  localparam int ShW      = SumW - RndShift;

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [HelpW-1:0]  help_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [ShW-1:0]    shifted_t;

endpackage

// File: rtl/quaternion_frame_rotation.sv
// Rotates a body-frame quaternion into the reference frame: ned = pose * body * conj(pose),
// computed exactly and then rounded to nearest (ties up) and saturated to 16 bits. Pose is
// signed Q1.14 and is used as given, without normalization. A transaction is taken on every
// cycle in which start is high (busy is always low), one per clock. Each result appears
// for a single cycle marked by done_o, in the order the transactions came in, after
// passing through the five-stage pipeline: p*b products, first Hamilton sums, helper*p
// products, second Hamilton sums, then rounding and saturation into the output
// register. The receiver cannot stall the block.
module quaternion_frame_rotation (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  qfr_pkg::comp_t pose_w_i,
  input  qfr_pkg::comp_t pose_x_i,
  input  qfr_pkg::comp_t pose_y_i,
  input  qfr_pkg::comp_t pose_z_i,
  input  qfr_pkg::comp_t body_w_i,
  input  qfr_pkg::comp_t body_x_i,
  input  qfr_pkg::comp_t body_y_i,
  input  qfr_pkg::comp_t body_z_i,
  output logic           done_o,
  output qfr_pkg::comp_t ned_w_o,
  output qfr_pkg::comp_t ned_x_o,
  output qfr_pkg::comp_t ned_y_o,
  output qfr_pkg::comp_t ned_z_o
);

  logic [4:0] vld_q;

  qfr_pkg::comp_t pose_in [4];
  qfr_pkg::comp_t body_in [4];

  qfr_pkg::prod_t  p1_d [4][4];
  qfr_pkg::prod_t  p1_q [4][4];
  qfr_pkg::comp_t  pose1_q [4];
  qfr_pkg::help_t  h_d [4];
  qfr_pkg::help_t  h_q [4];
  qfr_pkg::comp_t  pose2_q [4];
  qfr_pkg::prod2_t p2_d [4][4];
  qfr_pkg::prod2_t p2_q [4][4];
  qfr_pkg::sum_t   s_d [4];
  qfr_pkg::sum_t   s_q [4];
  qfr_pkg::comp_t  ned_d [4];
  qfr_pkg::comp_t  ned_q [4];

  assign busy = 1'b0;

  assign pose_in[0] = pose_w_i;
  assign pose_in[1] = pose_x_i;
  assign pose_in[2] = pose_y_i;
  assign pose_in[3] = pose_z_i;
  assign body_in[0] = body_w_i;
  assign body_in[1] = body_x_i;
  assign body_in[2] = body_y_i;
  assign body_in[3] = body_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start};
    end
  end

  // stage 1: all pose x body products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_d[i][j] = qfr_pkg::prod_t'(pose_in[i]) * qfr_pkg::prod_t'(body_in[j]);
      end
    end
  end

  // stage 2: helper = pose * body
  always_comb begin
    h_d[0] = qfr_pkg::help_t'(p1_q[0][0]) - qfr_pkg::help_t'(p1_q[1][1])
           - qfr_pkg::help_t'(p1_q[2][2]) - qfr_pkg::help_t'(p1_q[3][3]);
    h_d[1] = qfr_pkg::help_t'(p1_q[0][1]) + qfr_pkg::help_t'(p1_q[1][0])
           + qfr_pkg::help_t'(p1_q[2][3]) - qfr_pkg::help_t'(p1_q[3][2]);
    h_d[2] = qfr_pkg::help_t'(p1_q[0][2]) - qfr_pkg::help_t'(p1_q[1][3])
           + qfr_pkg::help_t'(p1_q[2][0]) + qfr_pkg::help_t'(p1_q[3][1]);
    h_d[3] = qfr_pkg::help_t'(p1_q[0][3]) + qfr_pkg::help_t'(p1_q[1][2])
           - qfr_pkg::help_t'(p1_q[2][1]) + qfr_pkg::help_t'(p1_q[3][0]);
  end

  // stage 3: helper x pose products; conjugate signs are folded into stage 4
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p2_d[i][j] = qfr_pkg::prod2_t'(h_q[i]) * qfr_pkg::prod2_t'(pose2_q[j]);
      end
    end
  end

  // stage 4: helper * conj(pose)
  always_comb begin
    s_d[0] =  qfr_pkg::sum_t'(p2_q[0][0]) + qfr_pkg::sum_t'(p2_q[1][1])
            + qfr_pkg::sum_t'(p2_q[2][2]) + qfr_pkg::sum_t'(p2_q[3][3]);
    s_d[1] = -qfr_pkg::sum_t'(p2_q[0][1]) + qfr_pkg::sum_t'(p2_q[1][0])
            - qfr_pkg::sum_t'(p2_q[2][3]) + qfr_pkg::sum_t'(p2_q[3][2]);
    s_d[2] = -qfr_pkg::sum_t'(p2_q[0][2]) + qfr_pkg::sum_t'(p2_q[1][3])
            + qfr_pkg::sum_t'(p2_q[2][0]) - qfr_pkg::sum_t'(p2_q[3][1]);
    s_d[3] = -qfr_pkg::sum_t'(p2_q[0][3]) - qfr_pkg::sum_t'(p2_q[1][2])
            + qfr_pkg::sum_t'(p2_q[2][1]) + qfr_pkg::sum_t'(p2_q[3][0]);
  end

  for (genvar k = 0; k < 4; k++) begin : g_rnd
    qfr_round_sat u_round_sat (
      .acc_i(s_q[k]),
      .res_o(ned_d[k])
    );
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    pose1_q <= pose_in;
    h_q     <= h_d;
    pose2_q <= pose1_q;
    p2_q    <= p2_d;
    s_q     <= s_d;
    ned_q   <= ned_d;
  end

  assign done_o  = vld_q[4];
  assign ned_w_o = ned_q[0];
  assign ned_x_o = ned_q[1];
  assign ned_y_o = ned_q[2];
  assign ned_z_o = ned_q[3];

endmodule

// File: rtl/qfr_round_sat.sv
module qfr_round_sat (
  input  qfr_pkg::sum_t  acc_i,
  output qfr_pkg::comp_t res_o
);

  localparam qfr_pkg::sum_t Half = qfr_pkg::sum_t'(1) <<< (qfr_pkg::RndShift - 1);

  qfr_pkg::sum_t     rounded;
  qfr_pkg::shifted_t shifted;
  logic              fits;

  always_comb begin
    // add half, then floor: ties go towards plus infinity
    rounded = acc_i + Half;
    shifted = qfr_pkg::shifted_t'(rounded >>> qfr_pkg::RndShift);
    // fits when every bit above the result's sign bit equals the sign
    fits = (shifted[qfr_pkg::ShW-1:qfr_pkg::CompW-1] == '0) ||
           (shifted[qfr_pkg::ShW-1:qfr_pkg::CompW-1] == '1);
    if (fits) begin
      res_o = shifted[qfr_pkg::CompW-1:0];
    end else if (shifted[qfr_pkg::ShW-1]) begin
      res_o = {1'b1, {(qfr_pkg::CompW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(qfr_pkg::CompW-1){1'b1}}};
    end
  end

endmodule

// File: dv/tb_quaternion_frame_rotation.sv
`timescale 1ns / 100ps

module tb_quaternion_frame_rotation;

  localparam int ClkHalf     = 4;
  localparam int MaxGap      = 16;
  localparam int CycleLimit  = 400000;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 12;
  localparam int NumUnit     = 1150;
  localparam int NumScaled   = 400;
  localparam int NumRaw      = 380;

  localparam qfr_pkg::comp_t PoseOne = qfr_pkg::comp_t'(1 << qfr_pkg::PoseFracBits);
  localparam qfr_pkg::comp_t CompMax = {1'b0, {(qfr_pkg::CompW-1){1'b1}}};
  localparam qfr_pkg::comp_t CompMin = {1'b1, {(qfr_pkg::CompW-1){1'b0}}};

  typedef struct packed {
    qfr_pkg::comp_t w;
    qfr_pkg::comp_t x;
    qfr_pkg::comp_t y;
    qfr_pkg::comp_t z;
  } quat_t;

  logic           clk_i    = 1'b0;
  logic           rst_ni   = 1'b0;
  logic           start    = 1'b0;
  qfr_pkg::comp_t pose_w_i = '0;
  qfr_pkg::comp_t pose_x_i = '0;
  qfr_pkg::comp_t pose_y_i = '0;
  qfr_pkg::comp_t pose_z_i = '0;
  qfr_pkg::comp_t body_w_i = '0;
  qfr_pkg::comp_t body_x_i = '0;
  qfr_pkg::comp_t body_y_i = '0;
  qfr_pkg::comp_t body_z_i = '0;
  logic           busy;
  logic           done_o;
  qfr_pkg::comp_t ned_w_o;
  qfr_pkg::comp_t ned_x_o;
  qfr_pkg::comp_t ned_y_o;
  qfr_pkg::comp_t ned_z_o;

  quat_t ned_expected_q[$];
  int    rotations_sent  = 0;
  int    directed_sent   = 0;
  int    results_checked = 0;
  int    error_count     = 0;
  int    cycle_count     = 0;
  bit    gap_free        = 1'b0;

  quaternion_frame_rotation u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .pose_w_i (pose_w_i),
    .pose_x_i (pose_x_i),
    .pose_y_i (pose_y_i),
    .pose_z_i (pose_z_i),
    .body_w_i (body_w_i),
    .body_x_i (body_x_i),
    .body_y_i (body_y_i),
    .body_z_i (body_z_i),
    .done_o   (done_o),
    .ned_w_o  (ned_w_o),
    .ned_x_o  (ned_x_o),
    .ned_y_o  (ned_y_o),
    .ned_z_o  (ned_z_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic quat_t mk_quat(int w, int x, int y, int z);
    return {qfr_pkg::comp_t'(w), qfr_pkg::comp_t'(x), qfr_pkg::comp_t'(y),
            qfr_pkg::comp_t'(z)};
  endfunction

  // exact sum carries scale 2^(2F); round half up, then clamp
  function automatic qfr_pkg::comp_t round_saturate(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (qfr_pkg::RndShift - 1))) >>> qfr_pkg::RndShift;
    if (r > CompMax) return CompMax;
    if (r < CompMin) return CompMin;
    return qfr_pkg::comp_t'(r[qfr_pkg::CompW-1:0]);
  endfunction

  // ned = pose * body * conj(pose), no normalization of pose
  function automatic quat_t rotate_frame(quat_t p, quat_t b);
    logic signed [63:0] pw, px, py, pz, bw, bx, by, bz;
    logic signed [63:0] hw, hx, hy, hz, cx, cy, cz;
    quat_t r;
    pw = $signed(p.w); px = $signed(p.x); py = $signed(p.y); pz = $signed(p.z);
    bw = $signed(b.w); bx = $signed(b.x); by = $signed(b.y); bz = $signed(b.z);
    hw = pw*bw - px*bx - py*by - pz*bz;
    hx = pw*bx + px*bw + py*bz - pz*by;
    hy = pw*by - px*bz + py*bw + pz*bx;
    hz = pw*bz + px*by - py*bx + pz*bw;
    cx = -px; cy = -py; cz = -pz;
    r.w = round_saturate(hw*pw - hx*cx - hy*cy - hz*cz);
    r.x = round_saturate(hw*cx + hx*pw + hy*cz - hz*cy);
    r.y = round_saturate(hw*cy - hx*cz + hy*pw + hz*cx);
    r.z = round_saturate(hw*cz + hx*cy - hy*cx + hz*pw);
    return r;
  endfunction

  function automatic quat_t rand_quat_bits();
    return {qfr_pkg::comp_t'($urandom), qfr_pkg::comp_t'($urandom),
            qfr_pkg::comp_t'($urandom), qfr_pkg::comp_t'($urandom)};
  endfunction

  function automatic int rand_q14();
    return int'($urandom_range(0, 2 * PoseOne)) - PoseOne;
  endfunction

  function automatic quat_t rand_unit_pose();
    real a, b, c, d, n;
    a = real'(int'($urandom_range(0, 65535)) - 32768);
    b = real'(int'($urandom_range(0, 65535)) - 32768);
    c = real'(int'($urandom_range(0, 65535)) - 32768);
    d = real'(int'($urandom_range(0, 65535)) - 32768);
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n < 1.0) return mk_quat(PoseOne, 0, 0, 0);
    n = n / real'(PoseOne);
    return mk_quat($rtoi(a / n), $rtoi(b / n), $rtoi(c / n), $rtoi(d / n));
  endfunction

  // body either full range or in +-0.5 of full scale so results stay mostly unclamped
  function automatic quat_t rand_body();
    if ($urandom_range(0, 1) == 0) return rand_quat_bits();
    return mk_quat(rand_q14(), rand_q14(), rand_q14(), rand_q14());
  endfunction

  task automatic send_rotation(input quat_t pose, input quat_t body);
    int unsigned gap;
    gap = gap_free ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    pose_w_i <= pose.w;
    pose_x_i <= pose.x;
    pose_y_i <= pose.y;
    pose_z_i <= pose.z;
    body_w_i <= body.w;
    body_x_i <= body.x;
    body_y_i <= body.y;
    body_z_i <= body.z;
    do @(posedge clk_i); while (busy);
    ned_expected_q.push_back(rotate_frame(pose, body));
    rotations_sent++;
  endtask

  task automatic test_axis_rotations();
    gap_free = 1'b0;
    send_rotation(mk_quat(PoseOne, 0, 0, 0), mk_quat(1000, -2000, 3000, -4000));
    send_rotation(mk_quat(PoseOne, 0, 0, 0), mk_quat(32767, 32767, 32767, 32767));
    send_rotation(mk_quat(PoseOne, 0, 0, 0), mk_quat(-32768, -32768, -32768, -32768));
    send_rotation(mk_quat(0, 0, 0, 0), mk_quat(32767, -32768, 1, -1));
    send_rotation(mk_quat(-PoseOne, 0, 0, 0), mk_quat(123, 4567, -8910, 11121));
    gap_free = 1'b1;
    send_rotation(mk_quat(0, PoseOne, 0, 0), mk_quat(100, 200, 300, 400));
    send_rotation(mk_quat(0, 0, PoseOne, 0), mk_quat(100, 200, 300, 400));
    send_rotation(mk_quat(0, 0, 0, -PoseOne), mk_quat(100, 200, 300, 400));
    // quarter turn about z
    send_rotation(mk_quat(11585, 0, 0, 11585), mk_quat(0, 10000, 0, 0));
    send_rotation(mk_quat(11585, -11585, 0, 0), mk_quat(-5, 0, 20000, -7));
    directed_sent += 10;
  endtask

  // |pose|^2 > 1 scales the result up, past full scale for the large bodies
  task automatic test_saturation();
    gap_free = 1'b0;
    send_rotation(mk_quat(PoseOne, PoseOne, PoseOne, PoseOne),
                  mk_quat(30000, 30000, -30000, 30000));
    send_rotation(mk_quat(-32768, 0, 0, 0), mk_quat(32767, -32768, 100, -100));
    send_rotation(mk_quat(32767, 32767, 32767, 32767), mk_quat(-32768, -32768, -32768, -32768));
    send_rotation(mk_quat(-32768, -32768, -32768, -32768), mk_quat(32767, 32767, 32767, 32767));
    send_rotation(mk_quat(0, -32768, 32767, 0), mk_quat(1, -20000, 20000, 9000));
    send_rotation(mk_quat(-PoseOne, -PoseOne, -PoseOne, -PoseOne), mk_quat(1, 1, 1, 1));
    directed_sent += 6;
  endtask

  // a single pose component of 0.5 gives a factor 1/4: body values of 2 mod 4 land exactly on halves
  task automatic test_rounding_ties();
    gap_free = 1'b1;
    send_rotation(mk_quat(8192, 0, 0, 0), mk_quat(2, -2, 6, -6));
    send_rotation(mk_quat(0, 0, 8192, 0), mk_quat(-6, 2, -2, 6));
    send_rotation(mk_quat(0, -8192, 0, 0), mk_quat(10, -10, 14, -14));
    gap_free = 1'b0;
    send_rotation(mk_quat(8192, 8192, 8192, 8192), mk_quat(1, 3, 5, 7));
    directed_sent += 4;
  endtask

  task automatic test_random_unit_pose();
    for (int i = 0; i < NumUnit; i++) begin
      if (i % 64 == 0) gap_free = ($urandom_range(0, 3) == 0);
      send_rotation(rand_unit_pose(), rand_body());
    end
  endtask

  task automatic test_random_scaled_pose();
    for (int i = 0; i < NumScaled; i++) begin
      if (i % 64 == 0) gap_free = ($urandom_range(0, 3) == 0);
      send_rotation(mk_quat(rand_q14(), rand_q14(), rand_q14(), rand_q14()), rand_body());
    end
  endtask

  task automatic test_random_raw_pose();
    for (int i = 0; i < NumRaw; i++) begin
      if (i % 64 == 0) gap_free = ($urandom_range(0, 3) == 0);
      send_rotation(rand_quat_bits(), rand_quat_bits());
    end
  endtask

  always @(posedge clk_i) begin
    quat_t ned_exp;
    if (rst_ni && done_o) begin
      if (ned_expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("ERROR: unexpected result w=%0d x=%0d y=%0d z=%0d",
                   ned_w_o, ned_x_o, ned_y_o, ned_z_o);
      end else begin
        ned_exp = ned_expected_q.pop_front();
        results_checked++;
        if (ned_w_o !== ned_exp.w || ned_x_o !== ned_exp.x ||
            ned_y_o !== ned_exp.y || ned_z_o !== ned_exp.z) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("ERROR: result %0d exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     results_checked, ned_exp.w, ned_exp.x, ned_exp.y, ned_exp.z,
                     ned_w_o, ned_x_o, ned_y_o, ned_z_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, ned_expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axis_rotations();
    test_saturation();
    test_rounding_ties();
    test_random_unit_pose();
    test_random_scaled_pose();
    test_random_raw_pose();
    start <= 1'b0;
    while (ned_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d rotations (%0d directed: axes, clamping, half ties), %0d checked",
             rotations_sent, directed_sent, results_checked);
    $display("Random poses: unit, scaled Q1.14 and raw bit patterns; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
